### hw/rtl/gain_slew_limiter_bank_defines.svh
// Assertion macros shared by the gain slew limiter bank RTL.
`ifndef GAIN_SLEW_LIMITER_BANK_DEFINES_SVH
`define GAIN_SLEW_LIMITER_BANK_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define GLB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gain slew limiter bank check failed");

// Next-cycle implication, checked outside reset.
`define GLB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gain slew limiter bank check failed");

`endif

### hw/rtl/glb_pkg.sv
// Package: constants, codes and control structs of the gain slew limiter bank.
`timescale 1ns / 1ps
`default_nettype none

package glb_pkg;

    localparam int NUM_CHANNELS_DEF = 12;
    localparam int VALUE_WIDTH_DEF  = 32;

    localparam int REQ_W  = 2;
    localparam int CH_W   = 4;
    localparam int STEP_W = 31;
    localparam int CFG_W  = 2;

    // request codes
    localparam logic [REQ_W-1:0] REQ_SET_CUR = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SET_TGT = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TICK    = 2'd2;

    // configuration register indexes
    localparam logic [CFG_W-1:0] CFG_KD_STEP  = 2'd0;
    localparam logic [CFG_W-1:0] CFG_KI_STEP  = 2'd1;
    localparam logic [CFG_W-1:0] CFG_KIB_STEP = 2'd2;
    localparam logic [CFG_W-1:0] CFG_KP_STEP  = 2'd3;

    localparam logic [STEP_W-1:0] KD_STEP_RST  = 31'd19661;
    localparam logic [STEP_W-1:0] KI_STEP_RST  = 31'd13;
    localparam logic [STEP_W-1:0] KIB_STEP_RST = 31'd13;
    localparam logic [STEP_W-1:0] KP_STEP_RST  = 31'd19661;

    // first channel of each gain group (channels past the kp group stay kp)
    localparam logic [CH_W:0] GRP_KI_FIRST  = 5'd3;
    localparam logic [CH_W:0] GRP_KIB_FIRST = 5'd6;
    localparam logic [CH_W:0] GRP_KP_FIRST  = 5'd9;

    typedef struct packed {
        logic set_cur;
        logic set_tgt;
        logic load_diff;
        logic update;
    } glb_cmd_t;

    typedef struct packed {
        logic moving;
        logic last;
    } glb_sts_t;

endpackage

`default_nettype wire

### hw/rtl/glb_req_if.sv
// Interface: request channel (set current, set target, tick).
`timescale 1ns / 1ps
`default_nettype none

interface glb_req_if
    import glb_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic [REQ_W-1:0]              req_type;
    logic [CH_W-1:0]               channel;
    logic signed [VALUE_WIDTH-1:0] value;

    modport source (output valid, req_type, channel, value, input ready);
    modport sink   (input valid, req_type, channel, value, output ready);
endinterface

`default_nettype wire

### hw/rtl/glb_rsp_if.sv
// Interface: update channel (one transaction per channel moved on a tick).
`timescale 1ns / 1ps
`default_nettype none

interface glb_rsp_if
    import glb_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic [CH_W-1:0]               out_channel;
    logic signed [VALUE_WIDTH-1:0] out_value;
    logic                          last;

    modport source (output valid, out_channel, out_value, last, input ready);
    modport sink   (input valid, out_channel, out_value, last, output ready);
endinterface

`default_nettype wire

### hw/rtl/glb_ctrl.sv
// Controller: accepts requests and sequences the channel scan of a tick.
`timescale 1ns / 1ps
`default_nettype none

module glb_ctrl
    import glb_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int IDX_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [REQ_W-1:0] in_type,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output glb_cmd_t              cmd,
    output logic [IDX_W-1:0]      idx,
    input  wire glb_sts_t         sts
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_CALC,
        S_EMIT
    } state_t;

    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(NUM_CHANNELS - 1);

    state_t           state_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             out_valid_reg;
    logic             idle_take;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign idx       = idx_reg;
    assign idle_take = in_ready && in_valid;

    always_comb
    begin
        cmd.set_cur   = idle_take && (in_type == REQ_SET_CUR);
        cmd.set_tgt   = idle_take && (in_type == REQ_SET_TGT);
        cmd.load_diff = (state_reg == S_SCAN) && sts.moving;
        cmd.update    = (state_reg == S_CALC);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (idle_take && (in_type == REQ_TICK))
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (sts.moving)
                        state_reg <= S_CALC;
                    else if (idx_reg == IDX_MAX)
                        state_reg <= S_IDLE;
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                S_CALC:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        // last means no later channel is moving
                        if (sts.last || (idx_reg == IDX_MAX))
                            state_reg <= S_IDLE;
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_SCAN;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### hw/rtl/glb_datapath.sv
// Datapath: channel state, step registers and the slew step arithmetic.
`timescale 1ns / 1ps
`default_nettype none

module glb_datapath
    import glb_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int VALUE_WIDTH  = VALUE_WIDTH_DEF,
    parameter int IDX_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [CFG_W-1:0]              cfg_index,
    input  wire logic [STEP_W-1:0]             cfg_wdata,
    input  wire logic [CH_W-1:0]               in_channel,
    input  wire logic signed [VALUE_WIDTH-1:0] in_value,
    input  wire glb_cmd_t                      cmd,
    input  wire logic [IDX_W-1:0]              idx,
    output glb_sts_t                           sts,
    output logic [CH_W-1:0]                    out_channel,
    output logic signed [VALUE_WIDTH-1:0]      out_value,
    output logic                               out_last
);

    localparam int DW    = VALUE_WIDTH + 1;
    localparam int CMP_W = (DW > STEP_W) ? DW : STEP_W;

    logic signed [VALUE_WIDTH-1:0] cur_reg [NUM_CHANNELS];
    logic signed [VALUE_WIDTH-1:0] tgt_reg [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0]       moving_reg;

    logic [STEP_W-1:0] kd_step_reg;
    logic [STEP_W-1:0] ki_step_reg;
    logic [STEP_W-1:0] kib_step_reg;
    logic [STEP_W-1:0] kp_step_reg;

    logic [DW-1:0] mag_reg;
    logic          neg_reg;

    logic [CH_W-1:0]               out_ch_reg;
    logic signed [VALUE_WIDTH-1:0] out_val_reg;
    logic                          out_last_reg;

    logic                          ch_ok;
    logic [IDX_W-1:0]              ch_idx;
    logic [IDX_W-1:0]              rd_idx;
    logic signed [VALUE_WIDTH-1:0] cur_rd;
    logic signed [VALUE_WIDTH-1:0] tgt_rd;
    logic signed [DW-1:0]          diff_up;
    logic signed [DW-1:0]          diff_dn;
    logic [STEP_W-1:0]             step;
    logic [CH_W:0]                 idx_ext;
    logic [CMP_W-1:0]              step_ext;
    logic                          far;
    logic signed [DW-1:0]          stepped;
    logic signed [VALUE_WIDTH-1:0] new_val;
    logic                          later_moving;

    assign ch_ok  = ({1'b0, in_channel} < (CH_W + 1)'(NUM_CHANNELS));
    assign ch_idx = in_channel[IDX_W-1:0];
    assign rd_idx = cmd.set_tgt ? ch_idx : idx;
    assign cur_rd = cur_reg[rd_idx];
    assign tgt_rd = tgt_reg[rd_idx];

    assign diff_up = DW'(tgt_rd) - DW'(cur_rd);
    assign diff_dn = DW'(cur_rd) - DW'(tgt_rd);

    assign idx_ext = (CH_W + 1)'(idx);

    always_comb
    begin
        if (idx_ext < GRP_KI_FIRST)
            step = kd_step_reg;
        else if (idx_ext < GRP_KIB_FIRST)
            step = ki_step_reg;
        else if (idx_ext < GRP_KP_FIRST)
            step = kib_step_reg;
        else
            step = kp_step_reg;
    end

    // step only gets used when it is below the gap, so it fits DW bits there
    assign step_ext = CMP_W'(step);
    assign far      = (CMP_W'(mag_reg) > step_ext);
    assign stepped  = neg_reg ? (DW'(cur_rd) - $signed(step_ext[DW-1:0]))
                              : (DW'(cur_rd) + $signed(step_ext[DW-1:0]));
    assign new_val  = far ? stepped[VALUE_WIDTH-1:0] : tgt_rd;

    always_comb
    begin
        later_moving = 1'b0;
        for (int j = 0; j < NUM_CHANNELS; j++)
        begin
            if (IDX_W'(j) > idx)
                later_moving = later_moving | moving_reg[j];
        end
    end

    assign sts.moving = moving_reg[idx];
    assign sts.last   = out_last_reg;

    assign out_channel = out_ch_reg;
    assign out_value   = out_val_reg;
    assign out_last    = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kd_step_reg  <= KD_STEP_RST;
            ki_step_reg  <= KI_STEP_RST;
            kib_step_reg <= KIB_STEP_RST;
            kp_step_reg  <= KP_STEP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_KD_STEP:  kd_step_reg  <= cfg_wdata;
                CFG_KI_STEP:  ki_step_reg  <= cfg_wdata;
                CFG_KIB_STEP: kib_step_reg <= cfg_wdata;
                CFG_KP_STEP:  kp_step_reg  <= cfg_wdata;
                default:      kp_step_reg  <= kp_step_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                cur_reg[i] <= '0;
                tgt_reg[i] <= '0;
            end
            moving_reg <= '0;
        end
        else
        begin
            if (cmd.set_cur && ch_ok)
                cur_reg[ch_idx] <= in_value;
            if (cmd.set_tgt && ch_ok)
            begin
                tgt_reg[ch_idx]    <= in_value;
                moving_reg[ch_idx] <= (in_value != cur_rd);
            end
            if (cmd.update)
            begin
                cur_reg[idx] <= new_val;
                if (!far)
                    moving_reg[idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_diff)
        begin
            neg_reg <= diff_up[DW-1];
            mag_reg <= diff_up[DW-1] ? diff_dn : diff_up;
        end
        if (cmd.update)
        begin
            out_ch_reg   <= CH_W'(idx);
            out_val_reg  <= new_val;
            out_last_reg <= !later_moving;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/gain_slew_limiter_bank.sv
// Top level: gain slew limiter bank, controller plus datapath.
//
// channel  dir   payload                         notes
// req      in    req_type, channel, value        set current / set target / tick
// rsp      out   out_channel, out_value, last    one per moving channel on a tick
// cfg      in    cfg_we, cfg_index, cfg_wdata    four step registers, write only
//
// A set transaction is written on acceptance and leaves the bank idle. A tick scans
// channels in order: an idle channel is passed over, and a moving one goes through the
// gap, step and output register states, the update waiting on rsp.ready as needed.
// The scan sequencer and its single step adder run the tick; req.ready is low
// while a tick is in progress. Reset clears all values, targets, moving flags
// and restores the default step sizes.
`timescale 1ns / 1ps
`default_nettype none

`include "gain_slew_limiter_bank_defines.svh"

module gain_slew_limiter_bank
    import glb_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int VALUE_WIDTH  = VALUE_WIDTH_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    glb_req_if.sink                req,
    glb_rsp_if.source              rsp,
    input  wire logic              cfg_we,
    input  wire logic [CFG_W-1:0]  cfg_index,
    input  wire logic [STEP_W-1:0] cfg_wdata
);

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    glb_cmd_t         cmd;
    glb_sts_t         sts;
    logic [IDX_W-1:0] idx;
    logic             in_ready;
    logic             out_valid;
    logic             set_take;

    assign req.ready = in_ready;
    assign rsp.valid = out_valid;
    assign set_take  = cmd.set_cur || cmd.set_tgt;

    glb_ctrl #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .IDX_W        (IDX_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (in_ready),
        .in_type   (req.req_type),
        .out_valid (out_valid),
        .out_ready (rsp.ready),
        .cmd       (cmd),
        .idx       (idx),
        .sts       (sts)
    );

    glb_datapath #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .VALUE_WIDTH  (VALUE_WIDTH),
        .IDX_W        (IDX_W)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .in_channel  (req.channel),
        .in_value    (req.value),
        .cmd         (cmd),
        .idx         (idx),
        .sts         (sts),
        .out_channel (rsp.out_channel),
        .out_value   (rsp.out_value),
        .out_last    (rsp.last)
    );

    // no new request while an update waits
    `GLB_ASSERT_NOW(a_no_req_during_update, clk, rst_n, out_valid, !in_ready)
    // updates only name real channels
    `GLB_ASSERT_NOW(a_update_channel_range, clk, rst_n, out_valid,
        ({1'b0, rsp.out_channel} < (CH_W + 1)'(NUM_CHANNELS)))
    // the tick ends with its last update
    `GLB_ASSERT_NEXT(a_last_ends_tick, clk, rst_n,
        out_valid && rsp.ready && rsp.last, in_ready)
    // a set transaction leaves the bank idle with no update pending
    `GLB_ASSERT_NEXT(a_set_single_cycle, clk, rst_n, set_take, in_ready && !out_valid)

endmodule

`default_nettype wire
